// ----- sv/dsil_pkg.sv -----
// Shared constants, types and operation codes for the descending sorted insert list.
package dsil_pkg;

    localparam int DEPTH = 16;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int IDX_W = $clog2(DEPTH);
    localparam int VAL_W = 32;
    localparam int OP_W  = 2;
    localparam int RIX_W = 4;

    typedef enum logic [OP_W-1:0] {
        OP_APPEND = 2'd0,
        OP_INSERT = 2'd1,
        OP_READ   = 2'd2
    } t_op;

    // Per-cycle command broadcast to every cell.
    typedef struct packed {
        logic fire;
        logic insert;
        logic append;
    } t_cell_ctl;

endpackage

// ----- sv/dsil_if.sv -----
// Valid/ready channel interfaces for requests and results.
interface dsil_in_if import dsil_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic [OP_W-1:0]         operation;
    logic signed [VAL_W-1:0] item_value;
    logic [RIX_W-1:0]        read_index;

    modport source (output valid, output operation, output item_value, output read_index,
                    input ready);
    modport sink (input valid, input operation, input item_value, input read_index,
                  output ready);
endinterface

interface dsil_out_if import dsil_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [VAL_W-1:0] entry_value;
    logic                    entry_valid;
    logic [CNT_W-1:0]        list_length;
    logic                    overflow;

    modport source (output valid, output entry_value, output entry_valid,
                    output list_length, output overflow, input ready);
    modport sink (input valid, input entry_value, input entry_valid,
                  input list_length, input overflow, output ready);
endinterface

// ----- sv/dsil_cell.sv -----
// One list slot: holds an entry, compares against the new value, shifts from its left neighbor.
module dsil_cell
    import dsil_pkg::*;
(
    input  logic                    i_clk,
    input  t_cell_ctl               i_ctl,
    input  logic signed [VAL_W-1:0] i_new_value,
    input  logic                    i_occupied,
    input  logic                    i_at_tail,
    input  logic                    i_left_found,
    input  logic signed [VAL_W-1:0] i_left_value,
    output logic                    o_found,
    output logic signed [VAL_W-1:0] o_value
);

    logic signed [VAL_W-1:0] r_value;
    logic                    w_stop;

    // The insert lands at the first occupied slot whose entry does not exceed the value.
    assign w_stop  = i_occupied && (i_new_value >= r_value);
    assign o_found = i_left_found || w_stop;
    assign o_value = r_value;

    always_ff @(posedge i_clk) begin
        if (i_ctl.fire) begin
            if (i_ctl.insert) begin
                if (i_left_found) begin
                    r_value <= i_left_value;
                end else if (w_stop || i_at_tail) begin
                    r_value <= i_new_value;
                end
            end else if (i_ctl.append && i_at_tail) begin
                r_value <= i_new_value;
            end
        end
    end

endmodule

// ----- sv/descending_sorted_insert_list_core.sv -----
// Top level of the descending sorted insert list: a row of cells plus count and result register.
//
// Usage:
//   i_in carries one request per handshake: append a value at the tail, insert it in
//   descending order, or read the entry at read_index. o_out returns exactly one result
//   per request with the read entry, its valid flag, the list length after the request
//   and an overflow flag set when a value was dropped because the list was full.
//   Every cell compares the incoming value with its own entry in the same cycle; the
//   insert position ripples as a found flag along the row, the cell there takes the new
//   value and every cell past it takes its left neighbor's entry, so an insert completes
//   in the cycle it is accepted. The result is registered and appears the cycle after.
//   Throughput: one request per cycle while the receiver takes results; set by the
//   single result register, which is refilled in the same cycle it is drained.
//   Reset clears the entry count and the result valid flag and holds i_in.ready low;
//   entry contents are not cleared, since only slots below the count are ever read.
//   When the receiver stalls, the result holds in the register and i_in.ready drops
//   until it is taken; the list state does not change meanwhile.
module descending_sorted_insert_list_core
    import dsil_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    dsil_in_if.sink          i_in,
    dsil_out_if.source       o_out
);

    logic [CNT_W-1:0]        r_count;
    logic [CNT_W-1:0]        n_count;
    logic                    r_out_valid;
    logic signed [VAL_W-1:0] r_entry_value;
    logic signed [VAL_W-1:0] n_entry_value;
    logic                    r_entry_valid;
    logic                    n_entry_valid;
    logic                    r_overflow;
    logic                    n_overflow;
    logic [CNT_W-1:0]        r_length;

    t_cell_ctl               w_ctl;
    logic                    w_fire;
    logic                    w_full;
    logic                    w_found [DEPTH];
    logic signed [VAL_W-1:0] w_value [DEPTH];
    logic [CNT_W+RIX_W-1:0]  w_idx_ext;

    assign i_in.ready = i_rst_n && (!r_out_valid || o_out.ready);
    assign w_fire     = i_in.valid && i_in.ready;
    assign w_full     = (r_count == CNT_W'(DEPTH));

    always_comb begin
        w_ctl.fire   = w_fire;
        w_ctl.insert = 1'b0;
        w_ctl.append = 1'b0;
        unique case (i_in.operation)
            OP_APPEND: w_ctl.append = 1'b1;
            OP_INSERT: w_ctl.insert = 1'b1;
            default:   ;
        endcase
    end

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic                    w_left_found;
        logic signed [VAL_W-1:0] w_left_value;

        if (g == 0) begin : g_head
            assign w_left_found = 1'b0;
            assign w_left_value = i_in.item_value;
        end else begin : g_body
            assign w_left_found = w_found[g-1];
            assign w_left_value = w_value[g-1];
        end

        dsil_cell u_cell (
            .i_clk        (i_clk),
            .i_ctl        (w_ctl),
            .i_new_value  (i_in.item_value),
            .i_occupied   (CNT_W'(g) < r_count),
            .i_at_tail    (CNT_W'(g) == r_count),
            .i_left_found (w_left_found),
            .i_left_value (w_left_value),
            .o_found      (w_found[g]),
            .o_value      (w_value[g])
        );
    end

    assign w_idx_ext = (CNT_W+RIX_W)'(i_in.read_index);

    always_comb begin
        n_count       = r_count;
        n_overflow    = 1'b0;
        n_entry_valid = 1'b0;
        n_entry_value = '0;
        if (w_ctl.append || w_ctl.insert) begin
            if (w_full) begin
                n_overflow = 1'b1;
            end else begin
                n_count = r_count + CNT_W'(1);
            end
        end else if (i_in.operation == OP_READ) begin
            if (w_idx_ext < (CNT_W+RIX_W)'(r_count)) begin
                n_entry_valid = 1'b1;
                n_entry_value = w_value[w_idx_ext[IDX_W-1:0]];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_fire) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload: load on every accepted request, hold otherwise.
    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_entry_value <= n_entry_value;
            r_entry_valid <= n_entry_valid;
            r_overflow    <= n_overflow;
            r_length      <= n_count;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.entry_value = r_entry_value;
    assign o_out.entry_valid = r_entry_valid;
    assign o_out.list_length = r_length;
    assign o_out.overflow    = r_overflow;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("entry count above depth");

    a_ovf_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.overflow |-> o_out.list_length == CNT_W'(DEPTH))
        else $error("overflow reported on a list that is not full");

    a_grow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fire && (w_ctl.append || w_ctl.insert) && !w_full
        |=> r_count == $past(r_count) + CNT_W'(1))
        else $error("count did not advance on a write");

    a_read_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.entry_valid |-> !o_out.overflow)
        else $error("read result flagged as overflow");

    a_hold_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_fire |=> r_count == $past(r_count))
        else $error("count changed without a request");

endmodule
